### sv/sia_pkg.sv
// sia_pkg: shared constants, codes and the microcode store for the sorted array.
// No dependencies. Used by the top level, the checkers and the testbench.
package sia_pkg;

    // Default sizing, handed to the top level's parameters
    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths on the ports
    localparam int ACTION_W  = 2;
    localparam int ITEM_W    = 32;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int CAP_W     = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    // Microprogram addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] UA_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] UA_INS0     = 4'd1;
    localparam logic [UPC_W-1:0] UA_INS1     = 4'd2;
    localparam logic [UPC_W-1:0] UA_INS2     = 4'd3;
    localparam logic [UPC_W-1:0] UA_INS3     = 4'd4;
    localparam logic [UPC_W-1:0] UA_LKP0     = 4'd5;
    localparam logic [UPC_W-1:0] UA_LKP1     = 4'd6;
    localparam logic [UPC_W-1:0] UA_REM0     = 4'd7;
    localparam logic [UPC_W-1:0] UA_REM1     = 4'd8;
    localparam logic [UPC_W-1:0] UA_REM2     = 4'd9;
    localparam logic [UPC_W-1:0] UA_REM3     = 4'd10;
    localparam logic [UPC_W-1:0] UA_REM4     = 4'd11;
    localparam logic [UPC_W-1:0] UA_FIN_OK   = 4'd12;
    localparam logic [UPC_W-1:0] UA_FIN_FULL = 4'd13;
    localparam logic [UPC_W-1:0] UA_FIN_BAD  = 4'd14;

    // Jump conditions
    localparam logic [3:0] JC_NEVER     = 4'd0;
    localparam logic [3:0] JC_ALWAYS    = 4'd1;
    localparam logic [3:0] JC_DISPATCH  = 4'd2;
    localparam logic [3:0] JC_FULL      = 4'd3;
    localparam logic [3:0] JC_PTR_ZERO  = 4'd4;
    localparam logic [3:0] JC_RD_GE_V   = 4'd5;
    localparam logic [3:0] JC_BAD_INDEX = 4'd6;
    localparam logic [3:0] JC_LAST      = 4'd7;
    localparam logic [3:0] JC_OUT_BUSY  = 4'd8;

    // When the side effects of a word apply
    localparam logic [1:0] GT_ALWAYS    = 2'd0;
    localparam logic [1:0] GT_TAKEN     = 2'd1;
    localparam logic [1:0] GT_NOT_TAKEN = 2'd2;

    // Read address source
    localparam logic [1:0] RS_PTR_M1 = 2'd0;
    localparam logic [1:0] RS_PTR_P1 = 2'd1;
    localparam logic [1:0] RS_POS    = 2'd2;

    // Write data source
    localparam logic WS_RDATA = 1'b0;
    localparam logic WS_VALUE = 1'b1;

    // Pointer operations
    localparam logic [2:0] PO_HOLD     = 3'd0;
    localparam logic [2:0] PO_LOAD_CNT = 3'd1;
    localparam logic [2:0] PO_LOAD_POS = 3'd2;
    localparam logic [2:0] PO_DEC      = 3'd3;
    localparam logic [2:0] PO_INC      = 3'd4;

    // Fill count operations
    localparam logic [1:0] CO_HOLD = 2'd0;
    localparam logic [1:0] CO_INC  = 2'd1;
    localparam logic [1:0] CO_DEC  = 2'd2;

    typedef struct packed {
        logic [3:0]          jcond;
        logic [UPC_W-1:0]    jtarget;
        logic                ret;       // fall through to idle instead of the next step
        logic [1:0]          gate;
        logic [1:0]          rd_sel;
        logic                wr_en;
        logic                wr_src;
        logic [2:0]          ptr_op;
        logic [1:0]          cnt_op;
        logic                got_load;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } uword_t;

    function automatic uword_t uw(
        input logic [3:0]          jcond,
        input logic [UPC_W-1:0]    jtarget,
        input logic                ret,
        input logic [1:0]          gate,
        input logic [1:0]          rd_sel,
        input logic                wr_en,
        input logic                wr_src,
        input logic [2:0]          ptr_op,
        input logic [1:0]          cnt_op,
        input logic                got_load,
        input logic                out_load,
        input logic [STATUS_W-1:0] status
    );
        uword_t w;
        w.jcond    = jcond;
        w.jtarget  = jtarget;
        w.ret      = ret;
        w.gate     = gate;
        w.rd_sel   = rd_sel;
        w.wr_en    = wr_en;
        w.wr_src   = wr_src;
        w.ptr_op   = ptr_op;
        w.cnt_op   = cnt_op;
        w.got_load = got_load;
        w.out_load = out_load;
        w.status   = status;
        return w;
    endfunction

    // Microprogram store
    function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        case (addr)
            UA_IDLE:     w = uw(JC_DISPATCH, UA_IDLE, 1'b0, GT_ALWAYS, RS_POS, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b0, 1'b0, ST_OK);
            // Insert: the hole walks down from the top until a smaller entry shows
            UA_INS0:     w = uw(JC_FULL, UA_FIN_FULL, 1'b0, GT_ALWAYS, RS_POS, 1'b0,
                                WS_VALUE, PO_LOAD_CNT, CO_HOLD, 1'b0, 1'b0, ST_OK);
            UA_INS1:     w = uw(JC_PTR_ZERO, UA_INS3, 1'b0, GT_ALWAYS, RS_PTR_M1, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b0, 1'b0, ST_OK);
            UA_INS2:     w = uw(JC_RD_GE_V, UA_INS1, 1'b0, GT_TAKEN, RS_PTR_M1, 1'b1,
                                WS_RDATA, PO_DEC, CO_HOLD, 1'b0, 1'b0, ST_OK);
            UA_INS3:     w = uw(JC_ALWAYS, UA_FIN_OK, 1'b0, GT_ALWAYS, RS_PTR_M1, 1'b1,
                                WS_VALUE, PO_HOLD, CO_INC, 1'b0, 1'b0, ST_OK);
            // Lookup
            UA_LKP0:     w = uw(JC_BAD_INDEX, UA_FIN_BAD, 1'b0, GT_ALWAYS, RS_POS, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b0, 1'b0, ST_OK);
            UA_LKP1:     w = uw(JC_ALWAYS, UA_FIN_OK, 1'b0, GT_ALWAYS, RS_POS, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b1, 1'b0, ST_OK);
            // Remove: capture the entry, then pull the later entries down
            UA_REM0:     w = uw(JC_BAD_INDEX, UA_FIN_BAD, 1'b0, GT_ALWAYS, RS_POS, 1'b0,
                                WS_VALUE, PO_LOAD_POS, CO_HOLD, 1'b0, 1'b0, ST_OK);
            UA_REM1:     w = uw(JC_NEVER, UA_IDLE, 1'b0, GT_ALWAYS, RS_POS, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b1, 1'b0, ST_OK);
            UA_REM2:     w = uw(JC_LAST, UA_REM4, 1'b0, GT_ALWAYS, RS_PTR_P1, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b0, 1'b0, ST_OK);
            UA_REM3:     w = uw(JC_ALWAYS, UA_REM2, 1'b0, GT_ALWAYS, RS_PTR_P1, 1'b1,
                                WS_RDATA, PO_INC, CO_HOLD, 1'b0, 1'b0, ST_OK);
            UA_REM4:     w = uw(JC_ALWAYS, UA_FIN_OK, 1'b0, GT_ALWAYS, RS_POS, 1'b0,
                                WS_VALUE, PO_HOLD, CO_DEC, 1'b0, 1'b0, ST_OK);
            // Finish: hold until the result register is free, then load it
            UA_FIN_OK:   w = uw(JC_OUT_BUSY, UA_FIN_OK, 1'b1, GT_NOT_TAKEN, RS_POS, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b0, 1'b1, ST_OK);
            UA_FIN_FULL: w = uw(JC_OUT_BUSY, UA_FIN_FULL, 1'b1, GT_NOT_TAKEN, RS_POS, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b0, 1'b1, ST_FULL);
            UA_FIN_BAD:  w = uw(JC_OUT_BUSY, UA_FIN_BAD, 1'b1, GT_NOT_TAKEN, RS_POS, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b0, 1'b1, ST_BAD_INDEX);
            default:     w = uw(JC_ALWAYS, UA_IDLE, 1'b0, GT_ALWAYS, RS_POS, 1'b0,
                                WS_VALUE, PO_HOLD, CO_HOLD, 1'b0, 1'b0, ST_OK);
        endcase
        return w;
    endfunction

    // Entry point of each operation
    function automatic logic [UPC_W-1:0] entry_point(input logic [ACTION_W-1:0] action);
        logic [UPC_W-1:0] a;
        case (action)
            ACT_INSERT: a = UA_INS0;
            ACT_LOOKUP: a = UA_LKP0;
            ACT_REMOVE: a = UA_REM0;
            ACT_NONE:   a = UA_FIN_OK;
            default:    a = UA_FIN_OK;
        endcase
        return a;
    endfunction

endpackage

### sv/sia_ram.sv
// sia_ram: generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/sorted_insertion_array_top.sv
// sorted_insertion_array_top: sorted value array driven by a microcoded sequencer.
// Depends on sia_pkg (codes, microcode store) and sia_ram (entry storage).
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------------
//  s_*      | in        | s_tvalid / s_tready | tuser: action; tdata: value, position
//  m_*      | out       | m_tvalid / m_tready | tuser: status; tdata: item, count
//  cfg_*    | in        | cfg_valid/cfg_ready | cfg_data: capacity
//
// One request at a time. Each moved entry takes a read and a write step, as the entry
// RAM's read port is registered.
// Reset clears the fill count and sets capacity to 64; entries are not cleared. A stalled
// result holds while the next request runs; only the final step waits for it to clear.
module sorted_insertion_array_top #(
    parameter int DEPTH       = sia_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sia_pkg::S_TDATA_W-1:0]       s_tdata,   // [31:0] value, [37:32] position
    input  logic [sia_pkg::ACTION_W-1:0]        s_tuser,   // [1:0] action
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sia_pkg::M_TDATA_W-1:0]       m_tdata,   // [31:0] item, [38:32] count
    output logic [sia_pkg::STATUS_W-1:0]        m_tuser,   // [1:0] status
    // Capacity register write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sia_pkg::CAP_W-1:0]           cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > sia_pkg::CAP_W) ? CNT_W : sia_pkg::CAP_W;
    localparam int VW_IN = (VALUE_WIDTH > sia_pkg::ITEM_W) ? VALUE_WIDTH : sia_pkg::ITEM_W;

    // Sequencer state
    logic [sia_pkg::UPC_W-1:0]    upc_reg, upc_next;
    sia_pkg::uword_t              uw;
    logic                         taken;
    logic                         effect;

    // Datapath registers
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             ptr_reg, ptr_next;
    logic [sia_pkg::CAP_W-1:0]    cap_reg;
    logic [VALUE_WIDTH-1:0]       val_reg, val_next;
    logic [sia_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0]       got_reg, got_next;

    // Result register
    logic                         out_valid_reg, out_valid_next;
    logic [sia_pkg::ITEM_W-1:0]   out_item_reg, out_item_next;
    logic [sia_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [sia_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    // RAM port
    logic                         ram_wr_en;
    logic [AW-1:0]                ram_wr_addr;
    logic [VALUE_WIDTH-1:0]       ram_wr_data;
    logic [AW-1:0]                ram_rd_addr;
    logic [VALUE_WIDTH-1:0]       ram_rd_data;

    // Derived values
    logic                         accept;
    logic [CNT_W-1:0]             ptr_m1;
    logic [CNT_W-1:0]             ptr_p1;
    logic [CMP_W-1:0]             cnt_cmp;
    logic [CMP_W-1:0]             pos_cmp;
    logic [CMP_W-1:0]             cap_cmp;
    logic [CMP_W-1:0]             limit;
    logic [VW_IN-1:0]             value_ext;
    logic [VW_IN-1:0]             got_ext;
    logic                         is_full;
    logic                         is_bad_index;
    logic                         is_last;

    assign uw        = sia_pkg::ucode(upc_reg);
    assign s_tready  = (upc_reg == sia_pkg::UA_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign ptr_m1    = ptr_reg - CNT_W'(1);
    assign ptr_p1    = ptr_reg + CNT_W'(1);
    assign cnt_cmp   = CMP_W'(cnt_reg);
    assign pos_cmp   = CMP_W'(pos_reg);
    assign cap_cmp   = CMP_W'(cap_reg);
    // Capacity above the physical depth saturates at the depth
    assign limit     = (cap_cmp < CMP_W'(DEPTH)) ? cap_cmp : CMP_W'(DEPTH);
    assign value_ext = VW_IN'(s_tdata[sia_pkg::ITEM_W-1:0]);
    assign got_ext   = VW_IN'(got_reg);

    assign is_full      = (cnt_cmp >= limit);
    assign is_bad_index = (pos_cmp >= cnt_cmp);
    // Last move of a remove: the slot above the pointer is beyond the filled range
    assign is_last      = ({1'b0, ptr_reg} + (CNT_W + 1)'(1)) >= {1'b0, cnt_reg};

    // Jump condition
    always_comb
    begin
        case (uw.jcond)
            sia_pkg::JC_NEVER:     taken = 1'b0;
            sia_pkg::JC_ALWAYS:    taken = 1'b1;
            sia_pkg::JC_DISPATCH:  taken = !accept;
            sia_pkg::JC_FULL:      taken = is_full;
            sia_pkg::JC_PTR_ZERO:  taken = (ptr_reg == '0);
            sia_pkg::JC_RD_GE_V:   taken = (ram_rd_data >= val_reg);
            sia_pkg::JC_BAD_INDEX: taken = is_bad_index;
            sia_pkg::JC_LAST:      taken = is_last;
            sia_pkg::JC_OUT_BUSY:  taken = out_valid_reg && !m_tready;
            default:               taken = 1'b0;
        endcase
    end

    // Side-effect gate: some steps act only on the taken or the fall-through path
    always_comb
    begin
        case (uw.gate)
            sia_pkg::GT_ALWAYS:    effect = 1'b1;
            sia_pkg::GT_TAKEN:     effect = taken;
            sia_pkg::GT_NOT_TAKEN: effect = !taken;
            default:               effect = 1'b0;
        endcase
    end

    // Next step: dispatch on the action, jump, return to idle, or advance
    always_comb
    begin
        if (uw.jcond == sia_pkg::JC_DISPATCH)
        begin
            upc_next = accept ? sia_pkg::entry_point(s_tuser) : sia_pkg::UA_IDLE;
        end
        else if (taken)
        begin
            upc_next = uw.jtarget;
        end
        else if (uw.ret)
        begin
            upc_next = sia_pkg::UA_IDLE;
        end
        else
        begin
            upc_next = upc_reg + sia_pkg::UPC_W'(1);
        end
    end

    // Entry RAM addressing: writes always land on the pointer slot
    always_comb
    begin
        case (uw.rd_sel)
            sia_pkg::RS_PTR_M1: ram_rd_addr = ptr_m1[AW-1:0];
            sia_pkg::RS_PTR_P1: ram_rd_addr = ptr_p1[AW-1:0];
            sia_pkg::RS_POS:    ram_rd_addr = pos_cmp[AW-1:0];
            default:            ram_rd_addr = pos_cmp[AW-1:0];
        endcase
    end

    assign ram_wr_en   = uw.wr_en && effect;
    assign ram_wr_addr = ptr_reg[AW-1:0];
    assign ram_wr_data = (uw.wr_src == sia_pkg::WS_RDATA) ? ram_rd_data : val_reg;

    // Datapath updates
    always_comb
    begin
        ptr_next = ptr_reg;
        if (effect)
        begin
            case (uw.ptr_op)
                sia_pkg::PO_HOLD:     ptr_next = ptr_reg;
                sia_pkg::PO_LOAD_CNT: ptr_next = cnt_reg;
                sia_pkg::PO_LOAD_POS: ptr_next = pos_cmp[CNT_W-1:0];
                sia_pkg::PO_DEC:      ptr_next = ptr_m1;
                sia_pkg::PO_INC:      ptr_next = ptr_p1;
                default:              ptr_next = ptr_reg;
            endcase
        end

        cnt_next = cnt_reg;
        if (effect)
        begin
            case (uw.cnt_op)
                sia_pkg::CO_HOLD: cnt_next = cnt_reg;
                sia_pkg::CO_INC:  cnt_next = cnt_reg + CNT_W'(1);
                sia_pkg::CO_DEC:  cnt_next = cnt_reg - CNT_W'(1);
                default:          cnt_next = cnt_reg;
            endcase
        end

        // Latch the request; the captured item starts at zero
        val_next = val_reg;
        pos_next = pos_reg;
        got_next = got_reg;
        if (accept)
        begin
            val_next = value_ext[VALUE_WIDTH-1:0];
            pos_next = s_tdata[sia_pkg::ITEM_W +: sia_pkg::POS_W];
            got_next = '0;
        end
        else if (uw.got_load && effect)
        begin
            got_next = ram_rd_data;
        end
    end

    // Result register: load on the finishing step, drop once taken
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        if (uw.out_load && effect)
        begin
            out_valid_next  = 1'b1;
            out_item_next   = got_ext[sia_pkg::ITEM_W-1:0];
            out_count_next  = cnt_cmp[sia_pkg::COUNT_W-1:0];
            out_status_next = uw.status;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= sia_pkg::UA_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= sia_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        got_reg        <= got_next;
        out_item_reg   <= out_item_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    sia_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_item_reg};
    assign m_tuser  = out_status_reg;

endmodule

### sv/sia_checker.sv
// sia_checker: port-level assertions for the sorted array, bound to the top level.
// Depends on sia_pkg for field widths and status codes.
module sia_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sia_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [sia_pkg::STATUS_W-1:0]  m_tuser
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // A refused request reports item zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == sia_pkg::ST_FULL || m_tuser == sia_pkg::ST_BAD_INDEX)
        |-> m_tdata[sia_pkg::ITEM_W-1:0] == '0)
    else $error("refused request carries a non-zero item");

    // One request at a time: ready drops after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

    // No result appears in the cycle right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result produced too early");

endmodule

bind sorted_insertion_array_top sia_checker u_sia_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/sorted_array_checker.sv
// sorted_array_checker: watches the request, result and capacity channels of the sorted
// array, keeps a shadow copy of its contents and compares every result with it.
// Depends on sia_pkg for field widths, operation codes and status codes.
module sorted_array_checker
    import sia_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [31:0] value, [37:32] position
    input  logic [ACTION_W-1:0]    s_tuser,   // [1:0] action
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,   // [31:0] item, [38:32] count
    input  logic [STATUS_W-1:0]    m_tuser,   // [1:0] status
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,
    output int                     errors,
    output int                     outstanding,
    output int                     stored
);

    typedef struct packed {
        logic [ITEM_W-1:0]   item;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } outcome_t;

    logic [ITEM_W-1:0] shadow [DEPTH_DEF];
    int                shadow_count = 0;
    logic [CAP_W-1:0]  shadow_cap   = CAP_RESET;
    outcome_t          awaited_results [$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
        stored      = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Apply one request to the shadow array and return the result it must give
    function automatic outcome_t apply_request(input logic [ACTION_W-1:0] act,
                                               input logic [ITEM_W-1:0] val,
                                               input logic [POS_W-1:0] pos);
        outcome_t res;
        int       limit;
        int       slot;
        res.item   = '0;
        res.status = ST_OK;
        limit      = (int'(shadow_cap) < DEPTH_DEF) ? int'(shadow_cap) : DEPTH_DEF;
        case (act)
            ACT_INSERT:
            begin
                if (shadow_count >= limit)
                    res.status = ST_FULL;
                else
                begin
                    // equal values: the new value goes ahead of existing equal entries, at the first entry not less
                    slot = 0;
                    while (slot < shadow_count && shadow[slot] < val)
                        slot++;
                    for (int k = shadow_count; k > slot; k--)
                        shadow[k] = shadow[k-1];
                    shadow[slot] = val;
                    shadow_count++;
                end
            end
            ACT_LOOKUP:
            begin
                if (int'(pos) < shadow_count)
                    res.item = shadow[pos];
                else
                    res.status = ST_BAD_INDEX;
            end
            ACT_REMOVE:
            begin
                if (int'(pos) < shadow_count)
                begin
                    res.item = shadow[pos];
                    for (int k = pos; k + 1 < shadow_count; k++)
                        shadow[k] = shadow[k+1];
                    shadow_count--;
                end
                else
                    res.status = ST_BAD_INDEX;
            end
            default:
                res.status = ST_OK;
        endcase
        res.count = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    task automatic check_result(input logic [ITEM_W-1:0] item,
                                input logic [STATUS_W-1:0] status,
                                input logic [COUNT_W-1:0] count);
        outcome_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("unrequested result item %h status %0d count %0d",
                                      item, status, count));
            return;
        end
        want = awaited_results.pop_front();
        if (item !== want.item)
            report_mismatch($sformatf("item %h, awaited %h", item, want.item));
        if (status !== want.status)
            report_mismatch($sformatf("status %0d, awaited %0d", status, want.status));
        if (count !== want.count)
            report_mismatch($sformatf("count %0d, awaited %0d", count, want.count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            shadow_cap   = CAP_RESET;
            awaited_results.delete();
        end
        else
        begin
            // retire first: a request taken at this edge cannot answer at the same edge
            if (m_tvalid && m_tready)
                check_result(m_tdata[ITEM_W-1:0], m_tuser, m_tdata[ITEM_W+COUNT_W-1:ITEM_W]);
            if (cfg_valid && cfg_ready)
                shadow_cap = cfg_data;
            if (s_tvalid && s_tready)
                awaited_results.push_back(apply_request(s_tuser, s_tdata[ITEM_W-1:0],
                                                        s_tdata[ITEM_W+POS_W-1:ITEM_W]));
        end
        outstanding = awaited_results.size();
        stored      = shadow_count;
    end

endmodule

### tb/sorted_insertion_array_top_tb.sv
// sorted_insertion_array_top_tb: drives requests, results back-pressure and capacity
// writes into the sorted array and gives the verdict. Depends on sia_pkg, the block
// sorted_insertion_array_top and the checker sorted_array_checker.
module sorted_insertion_array_top_tb;
    import sia_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [31:0] value, [37:32] position
    logic [ACTION_W-1:0]   s_tuser   = ACT_NONE;   // [1:0] action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [31:0] item, [38:32] count
    logic [STATUS_W-1:0]   m_tuser;          // [1:0] status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data  = '0;

    int   errors;
    int   outstanding;
    int   stored;

    // Random idling runs in stretches: a steady side never waits until it flips back
    logic tx_steady   = 1'b0;
    logic rx_steady   = 1'b0;
    // Raised once by the stimulus to ask the receiver for a long hold-off
    logic backlog_req = 1'b0;

    sorted_insertion_array_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sorted_array_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .stored      (stored)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Offer one request and hold it until the block takes it. Called at a rising edge;
    // returns at the edge where the request was accepted, with tvalid still high so a
    // back-to-back request does not need to lower it.
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [ITEM_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W-ITEM_W-POS_W){1'b0}}, pos, val};
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold until the block sits idle with no result waiting. Waits for the next edge first
    // so that a request taken at the calling edge is already in flight.
    task automatic wait_idle();
        @(posedge clk);
        while (!s_tready || m_tvalid) @(posedge clk);
    endtask

    // Write the capacity register with the block idle: drop the request channel, let
    // every awaited result drain, then hold the write until it is taken.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        wait_idle();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random request. Weights are percentages; 4 go to the unused code, the rest to lookups.
    // Positions mostly fall inside the filled part so lookups and removes do real work;
    // small values give plenty of equal entries.
    task automatic send_random(input int insert_pct, input int remove_pct);
        int                  pick;
        logic [ACTION_W-1:0] act;
        logic [ITEM_W-1:0]   val;
        logic [POS_W-1:0]    pos;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            act = ACT_NONE;
        else if (pick < 4 + insert_pct)
            act = ACT_INSERT;
        else if (pick < 4 + insert_pct + remove_pct)
            act = ACT_REMOVE;
        else
            act = ACT_LOOKUP;
        val = ($urandom_range(0, 1) == 0) ? ITEM_W'($urandom_range(0, 15)) : $urandom;
        if (stored > 0 && $urandom_range(0, 9) < 8)
            pos = POS_W'($urandom_range(0, stored - 1));
        else
            pos = POS_W'($urandom_range(0, 63));
        send_request(act, val, pos);
    endtask

    task automatic run_phase(input int requests, input int insert_pct, input int remove_pct);
        repeat (requests) send_random(insert_pct, remove_pct);
    endtask

    // Receiver: draw a wait before each result, hold tready low for it, then take the
    // result. On request do one long hold-off so the block backs up and stalls its input.
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 7);
            if (backlog_req)
            begin
                stall       = 400;
                backlog_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Main stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty array: every index is bad; the unused code only reports the count
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0);
        send_request(ACT_REMOVE, 32'h0000_0000, 6'd5);
        send_request(ACT_NONE,   32'hA5A5_A5A5, 6'd63);

        // Extremes of the value range, a duplicate and the sign bit on its own
        send_request(ACT_INSERT, 32'd7,          6'd63);
        send_request(ACT_INSERT, 32'd0,          6'd0);
        send_request(ACT_INSERT, 32'hFFFF_FFFF,  6'd21);
        send_request(ACT_INSERT, 32'd7,          6'd42);
        send_request(ACT_INSERT, 32'h8000_0000,  6'd0);
        send_request(ACT_INSERT, 32'd1,          6'd0);

        // Read back entries 0 to 3 and the top one, then indexes past the count
        send_request(ACT_LOOKUP, 32'd0, 6'd0);
        send_request(ACT_LOOKUP, 32'd0, 6'd1);
        send_request(ACT_LOOKUP, 32'd0, 6'd2);
        send_request(ACT_LOOKUP, 32'd0, 6'd3);
        send_request(ACT_LOOKUP, 32'd0, 6'd5);
        send_request(ACT_LOOKUP, 32'd0, 6'd63);
        send_request(ACT_REMOVE, 32'd0, 6'd63);

        // Remove from the middle, the bottom and the top
        send_request(ACT_REMOVE, 32'd0, 6'd2);
        send_request(ACT_REMOVE, 32'd0, 6'd0);
        send_request(ACT_REMOVE, 32'd0, 6'd3);

        // Capacity lowered below the count: inserts refused, lookup and remove still
        // work, and inserts come back once the count has dropped under the limit
        set_capacity(7'd2);
        send_request(ACT_INSERT, 32'd3, 6'd0);
        send_request(ACT_LOOKUP, 32'd0, 6'd2);
        send_request(ACT_REMOVE, 32'd0, 6'd0);
        send_request(ACT_INSERT, 32'd4, 6'd0);
        send_request(ACT_REMOVE, 32'd0, 6'd1);
        send_request(ACT_INSERT, 32'd9, 6'd0);

        // Capacity beyond the array depth saturates: fill to the top and press on.
        // Midway, ask for the long receiver hold-off while requests keep coming.
        set_capacity(7'd127);
        run_phase(60, 80, 5);
        backlog_req = 1'b1;
        run_phase(60, 80, 5);

        // Small limit with the array well above it
        set_capacity(7'd10);
        run_phase(80, 40, 35);

        // Zero capacity: every insert refused while the array drains
        set_capacity(7'd0);
        run_phase(30, 40, 40);

        set_capacity(7'd1);
        run_phase(40, 45, 30);

        set_capacity(7'd100);
        run_phase(60, 70, 10);
        run_phase(60, 30, 50);

        // Back to the reset value
        set_capacity(7'd64);
        run_phase(130, 45, 30);

        // Drain and let the block settle before the verdict; an unanswered request fails
        s_tvalid <= 1'b0;
        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop, several times the slowest correct run
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
